/* hw/rtl/ffha_pkg.sv */
// Shared constants, codes and controller/datapath interface types
// for the first-fit heap allocator. No dependencies.
package ffha_pkg;

	// heap geometry
	localparam int HEAP_BYTES   = 4096;
	localparam int ALIGN_BYTES  = 4;
	localparam int HEADER_BYTES = 8;
	localparam int HDR = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
	localparam int PW    = 13;                     // header position width (0..HEAP_BYTES)
	localparam int DEPTH = HEAP_BYTES / ALIGN_BYTES;
	localparam int IW    = 10;                     // header store index width

	typedef logic [PW-1:0] pos_t;
	localparam pos_t END_POS = pos_t'(HEAP_BYTES);
	localparam logic [7:0] MIN_SPLIT_RESET = 8'd12;

	// request kinds
	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_SHRINK = 2'd2;

	// response codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FAIL    = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE, OP_CLR, OP_LOAD, OP_ALC_START, OP_ALC_FIT, OP_ALC_STEP,
		OP_SPL_WT, OP_SPL_WH, OP_SPL_WN, OP_FND_RD, OP_FND_CHK, OP_FREE_W,
		OP_SHR_T, OP_MRG_RDM, OP_MRG_N, OP_MRG_JN, OP_MRG_WPN, OP_MRG_P,
		OP_MRG_JP, OP_MRG_WPP, OP_RESP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] rsp;
	} cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic [1:0] kind;
		logic       zero;
		logic       oversz;
		logic       find_bad;
		logic       h_zero;
		logic       lf_end;
		logic       fit;
		logic       n_le_p;
		logic       next_end;
		logic       ph_ge_h;
		logic       next_ne_h;
		logic       mn_ok;
		logic       mp_ok;
		logic       split_ok;
		logic       out_free;
	} sts_t;

endpackage

/* hw/rtl/ffha_ctrl.sv */
// Request sequencer of the heap allocator: walks, split, free, merge steps.
// Depends on ffha_pkg; drives ffha_dp through cmd_t, reads sts_t.
module ffha_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ffha_pkg::sts_t sts,
	output ffha_pkg::cmd_t cmd
);
	import ffha_pkg::*;

	typedef enum logic [20:0] {
		S_CLR     = 21'd1 << 0,
		S_IDLE    = 21'd1 << 1,
		S_DEC     = 21'd1 << 2,
		S_ALC_CHK = 21'd1 << 3,
		S_SPL_T   = 21'd1 << 4,
		S_SPL_H   = 21'd1 << 5,
		S_SPL_N   = 21'd1 << 6,
		S_FND_H   = 21'd1 << 7,
		S_FND_P   = 21'd1 << 8,
		S_FND_OK  = 21'd1 << 9,
		S_MRG_RD  = 21'd1 << 10,
		S_MRG_M   = 21'd1 << 11,
		S_MRG_N   = 21'd1 << 12,
		S_MRG_W2  = 21'd1 << 13,
		S_MRG_RD2 = 21'd1 << 14,
		S_MRG_M2  = 21'd1 << 15,
		S_MRG_P   = 21'd1 << 16,
		S_MRG_W4  = 21'd1 << 17,
		S_OK      = 21'd1 << 18,
		S_FAIL    = 21'd1 << 19,
		S_IGN     = 21'd1 << 20
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		cmd.rsp = ST_DONE;
		unique case (state_q)
			S_CLR: begin
				cmd.op = OP_CLR;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				priority if (sts.kind == KIND_ALLOC) begin
					if (sts.zero || sts.oversz || sts.lf_end) begin
						state_d = S_FAIL;
					end else begin
						cmd.op  = OP_ALC_START;
						state_d = S_ALC_CHK;
					end
				end else if (sts.kind == KIND_FREE) begin
					if (sts.find_bad) begin
						state_d = S_IGN;
					end else begin
						cmd.op  = OP_FND_RD;
						state_d = S_FND_H;
					end
				end else if (sts.kind == KIND_SHRINK) begin
					if (sts.oversz) begin
						state_d = S_FAIL;
					end else if (sts.find_bad) begin
						state_d = S_IGN;
					end else begin
						cmd.op  = OP_FND_RD;
						state_d = S_FND_H;
					end
				end else begin
					state_d = S_IGN;
				end
			end
			// first-fit walk, one header per cycle
			S_ALC_CHK: begin
				priority if (sts.fit) begin
					cmd.op  = OP_ALC_FIT;
					state_d = S_SPL_T;
				end else if (sts.n_le_p || sts.next_end) begin
					state_d = S_FAIL;
				end else begin
					cmd.op = OP_ALC_STEP;
				end
			end
			S_SPL_T: begin
				cmd.op  = OP_SPL_WT;
				state_d = S_SPL_H;
			end
			S_SPL_H: begin
				cmd.op  = OP_SPL_WH;
				state_d = S_SPL_N;
			end
			S_SPL_N: begin
				cmd.op  = OP_SPL_WN;
				state_d = (sts.kind == KIND_ALLOC) ? S_OK : S_MRG_RD;
			end
			// block lookup by payload offset
			S_FND_H: begin
				cmd.op = OP_FND_CHK;
				priority if (sts.h_zero) state_d = S_FND_OK;
				else if (sts.ph_ge_h) state_d = S_IGN;
				else state_d = S_FND_P;
			end
			S_FND_P: begin
				state_d = sts.next_ne_h ? S_IGN : S_FND_OK;
			end
			S_FND_OK: begin
				if (sts.kind == KIND_FREE) begin
					cmd.op  = OP_FREE_W;
					state_d = S_MRG_RD;
				end else begin
					cmd.op  = OP_SHR_T;
					state_d = sts.split_ok ? S_SPL_T : S_OK;
				end
			end
			// merge with following block
			S_MRG_RD: begin
				cmd.op  = OP_MRG_RDM;
				state_d = S_MRG_M;
			end
			S_MRG_M: begin
				cmd.op  = OP_MRG_N;
				state_d = S_MRG_N;
			end
			S_MRG_N: begin
				if (sts.mn_ok) begin
					cmd.op  = OP_MRG_JN;
					state_d = S_MRG_W2;
				end else begin
					state_d = S_MRG_RD2;
				end
			end
			S_MRG_W2: begin
				cmd.op  = OP_MRG_WPN;
				state_d = S_MRG_RD2;
			end
			// merge with preceding block
			S_MRG_RD2: begin
				cmd.op  = OP_MRG_RDM;
				state_d = S_MRG_M2;
			end
			S_MRG_M2: begin
				cmd.op  = OP_MRG_P;
				state_d = S_MRG_P;
			end
			S_MRG_P: begin
				if (sts.mp_ok) begin
					cmd.op  = OP_MRG_JP;
					state_d = S_MRG_W4;
				end else begin
					state_d = S_OK;
				end
			end
			S_MRG_W4: begin
				cmd.op  = OP_MRG_WPP;
				state_d = S_OK;
			end
			// response, once the output slot is free
			S_OK, S_FAIL, S_IGN: begin
				cmd.rsp = (state_q == S_OK) ? ST_DONE :
					(state_q == S_FAIL) ? ST_FAIL : ST_IGNORED;
				if (sts.out_free) begin
					cmd.op  = OP_RESP;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

endmodule

/* hw/rtl/ffha_dp.sv */
// Datapath of the heap allocator: header store, walk registers, result slot.
// Depends on ffha_pkg; steered by ffha_ctrl through cmd_t.
module ffha_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  ffha_pkg::cmd_t cmd,
	output ffha_pkg::sts_t sts,
	input  logic [1:0]     in_kind,
	input  logic [15:0]    in_size,
	input  logic [15:0]    in_offset,
	input  logic           cfg_valid,
	input  logic [7:0]     cfg_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     out_status,
	output logic [11:0]    out_pay
);
	import ffha_pkg::*;

	// header store, one field per array so single fields can be written
	pos_t       mem_next [DEPTH];
	pos_t       mem_prev [DEPTH];
	logic       mem_used [DEPTH];

	pos_t       rdn_q, rdp_q;
	logic       rdu_q, rde_q;
	pos_t       rd_next, rd_prev;
	logic       rd_used;
	pos_t       raddr;

	pos_t       waddr, wnext, wprev;
	logic       wused, we_n, we_p, we_u;

	logic [IW-1:0] clr_q;
	logic       clr_done_q;

	logic [1:0] kind_q;
	logic [16:0] s_q;
	logic [15:0] off_q;
	logic       zero_q;
	pos_t       h_q, p_q, n_q, t_q, m_q, nn_q, lf_q;
	logic [7:0] min_q;

	logic       out_valid_q;
	logic [1:0] out_status_q;
	logic [11:0] out_pay_q;

	logic [15:0] hfull, in_hfull;
	logic [16:0] s_in;
	logic [13:0] diff, hp8, have;
	logic [17:0] need;
	logic [17:0] lhs;
	logic [16:0] t_sum;
	logic [11:0] alloc_pay;

	// read data, end header is fixed and always used
	assign rd_next = rde_q ? END_POS : rdn_q;
	assign rd_prev = rde_q ? END_POS : rdp_q;
	assign rd_used = rde_q ? 1'b1 : rdu_q;

	// read address
	always_comb begin
		unique case (cmd.op)
			OP_ALC_START: raddr = lf_q;
			OP_ALC_STEP:  raddr = rd_next;
			OP_FND_RD:    raddr = h_q;
			OP_FND_CHK:   raddr = rd_prev;
			OP_MRG_RDM:   raddr = m_q;
			OP_MRG_N:     raddr = rd_next;
			OP_MRG_P:     raddr = rd_prev;
			default:      raddr = '0;
		endcase
	end

	// write port
	always_comb begin
		waddr = '0;
		wnext = '0;
		wprev = '0;
		wused = 1'b0;
		we_n  = 1'b0;
		we_p  = 1'b0;
		we_u  = 1'b0;
		unique case (cmd.op)
			OP_CLR: begin
				waddr = {1'b0, clr_q, 2'b00};
				wnext = (clr_q == '0) ? END_POS : '0;
				we_n  = 1'b1;
				we_p  = 1'b1;
				we_u  = 1'b1;
			end
			OP_SPL_WT: begin
				waddr = t_q;
				wnext = n_q;
				wprev = h_q;
				we_n  = 1'b1;
				we_p  = 1'b1;
				we_u  = 1'b1;
			end
			OP_SPL_WH: begin
				waddr = h_q;
				wnext = t_q;
				wused = 1'b1;
				we_n  = 1'b1;
				we_u  = (kind_q == KIND_ALLOC);
			end
			OP_SPL_WN: begin
				waddr = n_q;
				wprev = t_q;
				we_p  = 1'b1;
			end
			OP_FREE_W: begin
				waddr = h_q;
				we_u  = 1'b1;
			end
			OP_MRG_JN: begin
				waddr = m_q;
				wnext = rd_next;
				we_n  = 1'b1;
			end
			OP_MRG_WPN: begin
				waddr = nn_q;
				wprev = m_q;
				we_p  = 1'b1;
			end
			OP_MRG_JP: begin
				waddr = p_q;
				wnext = n_q;
				we_n  = 1'b1;
			end
			OP_MRG_WPP: begin
				waddr = n_q;
				wprev = p_q;
				we_p  = 1'b1;
			end
			default: ;
		endcase
	end

	// memory arrays; writes to the end header are dropped
	always_ff @(posedge clk) begin
		if (!waddr[PW-1]) begin
			if (we_n) mem_next[waddr[IW+1:2]] <= wnext;
			if (we_p) mem_prev[waddr[IW+1:2]] <= wprev;
			if (we_u) mem_used[waddr[IW+1:2]] <= wused;
		end
		rdn_q <= mem_next[raddr[IW+1:2]];
		rdp_q <= mem_prev[raddr[IW+1:2]];
		rdu_q <= mem_used[raddr[IW+1:2]];
		rde_q <= raddr[PW-1];
	end

	// arithmetic
	assign in_hfull  = in_offset - 16'(HDR);
	assign s_in      = ({1'b0, in_size} + 17'(ALIGN_BYTES - 1)) & ~17'(ALIGN_BYTES - 1);
	assign hfull     = off_q - 16'(HDR);
	assign diff      = {1'b0, rd_next} - {1'b0, p_q};
	assign need      = {1'b0, s_q} + 18'(2 * HDR);
	assign hp8       = {1'b0, h_q} + 14'(HDR);
	assign have      = ({1'b0, n_q} > hp8) ? ({1'b0, n_q} - hp8) : '0;
	assign lhs       = {1'b0, s_q} + 18'(HDR) + {10'b0, min_q};
	assign t_sum     = ((kind_q == KIND_ALLOC) ? {4'b0, p_q} : {4'b0, h_q})
		+ 17'(HDR) + s_q;
	assign alloc_pay = hp8[11:0];

	// status toward the controller
	always_comb begin
		sts.clr_done  = clr_done_q;
		sts.kind      = kind_q;
		sts.zero      = zero_q;
		sts.oversz    = (s_q > 17'(HEAP_BYTES));
		sts.find_bad  = (off_q < 16'(HDR)) || (hfull >= 16'(HEAP_BYTES))
			|| (hfull[1:0] != 2'b00);
		sts.h_zero    = (h_q == '0);
		sts.lf_end    = (lf_q >= END_POS);
		sts.fit       = !rd_used && (rd_next > p_q) && ({4'b0, diff} >= need);
		sts.n_le_p    = (rd_next <= p_q);
		sts.next_end  = (rd_next >= END_POS);
		sts.ph_ge_h   = (rd_prev >= h_q);
		sts.next_ne_h = (rd_next != h_q);
		sts.mn_ok     = (n_q != m_q) && !rd_used && (n_q != END_POS);
		sts.mp_ok     = (p_q != m_q) && !rd_used;
		sts.split_ok  = (lhs < {4'b0, have});
		sts.out_free  = !out_valid_q || out_ready;
	end

	// control registers: clear sweep, lowest free, config, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			clr_done_q  <= 1'b0;
			lf_q        <= '0;
			min_q       <= MIN_SPLIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) min_q <= cfg_data;
			if (cmd.op == OP_CLR) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == '1) clr_done_q <= 1'b1;
			end
			// a new result may replace the one taken in the same cycle
			if (cmd.op == OP_RESP) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_SPL_WN: begin
					if (kind_q == KIND_ALLOC) begin
						if (h_q == lf_q) lf_q <= t_q;
					end else if (t_q < lf_q) begin
						lf_q <= t_q;
					end
				end
				OP_FREE_W:  if (h_q < lf_q) lf_q <= h_q;
				OP_MRG_JN:  if (lf_q == n_q) lf_q <= m_q;
				OP_MRG_JP:  if (lf_q == m_q) lf_q <= p_q;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				kind_q <= in_kind;
				s_q    <= s_in;
				off_q  <= in_offset;
				zero_q <= (in_size == '0);
				h_q    <= in_hfull[PW-1:0];
			end
			OP_ALC_START: p_q <= lf_q;
			OP_ALC_FIT: begin
				n_q <= rd_next;
				h_q <= p_q;
				t_q <= t_sum[PW-1:0];
			end
			OP_ALC_STEP: p_q <= rd_next;
			OP_SPL_WN:   m_q <= t_q;
			OP_FND_CHK: begin
				n_q <= rd_next;
				p_q <= rd_prev;
			end
			OP_FREE_W:   m_q <= h_q;
			OP_SHR_T:    t_q <= t_sum[PW-1:0];
			OP_MRG_N:    n_q <= rd_next;
			OP_MRG_JN:   nn_q <= rd_next;
			OP_MRG_P: begin
				p_q <= rd_prev;
				n_q <= rd_next;
			end
			OP_RESP: begin
				out_status_q <= cmd.rsp;
				if (cmd.rsp != ST_DONE) out_pay_q <= '0;
				else if (kind_q == KIND_ALLOC) out_pay_q <= alloc_pay;
				else if (kind_q == KIND_SHRINK) out_pay_q <= off_q[11:0];
				else out_pay_q <= '0;
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_pay    = out_pay_q;

endmodule

/* hw/rtl/first_fit_heap_allocator.sv */
// First-fit heap allocator with coalescing, one item at a time. Shrink may split off the
// tail of its block; allocate reads the headers in turn until one fits or the walk ends.
// The next item can be accepted once the result is registered; a stalled result does not
// block that accept, but the following result then waits in its response state.
// Async reset, then a clear of every header store entry; no item accepted meanwhile (config is).
// Top level: joins ffha_ctrl and ffha_dp; depends on ffha_pkg.
module first_fit_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] size, [31:16] offset
	input  logic [1:0]  s_axis_tuser,  // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [11:0] payload_offset, [15:12] zero
	output logic [1:0]  m_axis_tuser,  // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data       // min_split_bytes
);
	import ffha_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic [11:0] pay;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffha_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_kind    (s_axis_tuser),
		.in_size    (s_axis_tdata[15:0]),
		.in_offset  (s_axis_tdata[31:16]),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_pay    (pay)
	);

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {4'b0, pay};

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.clr_done |-> !s_axis_tready)
		else $error("item accepted during header clear");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item accepted while busy");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("undefined status code");
	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata == '0)
		else $error("payload offset set on a failed item");
`endif

endmodule

/* bench/first_fit_heap_allocator_test.sv */
// Self-checking bench for first_fit_heap_allocator: drives allocate, free and shrink
// requests and compares every response against an in-bench heap predictor.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
module first_fit_heap_allocator_test;
	import ffha_pkg::*;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] size;
		logic [15:0] offset;
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic [11:0] payload;
	} response_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	first_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// heap shadow state
	int unsigned hp_next [0:HEAP_BYTES];
	int unsigned hp_prev [0:HEAP_BYTES];
	bit          hp_used [0:HEAP_BYTES];
	int unsigned low_free;
	int unsigned split_min;

	request_t    pending_reqs[$];
	response_t   expected_rsps[$];
	int unsigned live_blocks[$];   // candidate payload offsets for free and shrink requests
	int          mismatches;
	bit          stim_done;

	// phase control for config writes
	bit          cfg_req;
	logic [7:0]  cfg_val;
	int          send_gap;
	int          recv_gap;
	int unsigned recv_draw;

	// handshakes seen at the last rising edge
	bit          in_acc;
	bit          out_acc;

	function automatic int unsigned clip(int unsigned p);
		return (p <= HEAP_BYTES) ? p : HEAP_BYTES;
	endfunction

	function automatic int unsigned align_up(int unsigned s);
		int unsigned r;
		r = s % ALIGN_BYTES;
		return r ? s + (ALIGN_BYTES - r) : s;
	endfunction

	function automatic void heap_clear();
		for (int i = 0; i <= HEAP_BYTES; i++) begin
			hp_next[i] = 0;
			hp_prev[i] = 0;
			hp_used[i] = 0;
		end
		hp_next[0] = HEAP_BYTES;
		hp_next[HEAP_BYTES] = HEAP_BYTES;
		hp_prev[HEAP_BYTES] = HEAP_BYTES;
		hp_used[HEAP_BYTES] = 1;
		low_free = 0;
		split_min = MIN_SPLIT_RESET;
	endfunction

	// header position for a payload offset; HEAP_BYTES+1 when not a block header
	function automatic int unsigned locate_header(int unsigned off);
		int unsigned h;
		if (off < HDR) return HEAP_BYTES + 1;
		h = off - HDR;
		if (h >= HEAP_BYTES) return HEAP_BYTES + 1;
		if (h == 0) return 0;
		if (hp_next[clip(hp_prev[h])] != h) return HEAP_BYTES + 1;
		if (hp_prev[h] >= h) return HEAP_BYTES + 1;
		return h;
	endfunction

	function automatic void coalesce(int unsigned m);
		int unsigned n, p;
		n = hp_next[clip(m)];
		if (n != m && !hp_used[clip(n)] && n != HEAP_BYTES) begin
			if (low_free == n) low_free = m;
			hp_next[clip(m)] = hp_next[clip(n)];
			hp_prev[clip(hp_next[clip(n)])] = m;
		end
		p = hp_prev[clip(m)];
		if (p != m && !hp_used[clip(p)]) begin
			if (low_free == m) low_free = p;
			hp_next[clip(p)] = hp_next[clip(m)];
			hp_prev[clip(hp_next[clip(m)])] = p;
		end
	endfunction

	function automatic int unsigned carve(int unsigned h, int unsigned sz);
		int unsigned t;
		t = h + HDR + sz;
		hp_used[clip(t)] = 0;
		hp_next[clip(t)] = hp_next[clip(h)];
		hp_prev[clip(t)] = h;
		hp_next[clip(h)] = t;
		if (hp_next[clip(t)] != HEAP_BYTES) hp_prev[clip(hp_next[clip(t)])] = t;
		return t;
	endfunction

	// apply one request to the shadow heap and return the response it must produce
	function automatic response_t heap_apply(request_t rq);
		response_t   rs;
		int unsigned s, p, n, g, guard, h, have, t;
		rs.status = ST_IGNORED;
		rs.payload = 0;
		if (rq.kind == KIND_ALLOC) begin
			rs.status = ST_FAIL;
			s = align_up(rq.size);
			if (rq.size != 0 && s <= HEAP_BYTES) begin
				p = low_free;
				guard = 0;
				while (p < HEAP_BYTES && guard <= HEAP_BYTES) begin
					n = hp_next[p];
					if (!hp_used[p] && n > p && n - p >= s + 2 * HDR) begin
						void'(carve(p, s));
						hp_used[p] = 1;
						if (p == low_free) begin
							g = 0;
							while (hp_used[clip(low_free)] && low_free != HEAP_BYTES
							       && g <= HEAP_BYTES) begin
								low_free = clip(hp_next[clip(low_free)]);
								g++;
							end
						end
						rs.status = ST_DONE;
						rs.payload = 12'(p + HDR);
						break;
					end
					if (n <= p) break;
					p = n;
					guard++;
				end
			end
		end else if (rq.kind == KIND_FREE) begin
			h = locate_header(rq.offset);
			if (h < HEAP_BYTES) begin
				hp_used[h] = 0;
				if (h < low_free) low_free = h;
				coalesce(h);
				rs.status = ST_DONE;
			end
		end else if (rq.kind == KIND_SHRINK) begin
			s = align_up(rq.size);
			if (s > HEAP_BYTES) begin
				rs.status = ST_FAIL;
			end else begin
				h = locate_header(rq.offset);
				if (h < HEAP_BYTES) begin
					n = hp_next[h];
					have = (n > h + HDR) ? n - h - HDR : 0;
					if (s + HDR + split_min < have) begin
						t = carve(h, s);
						if (t < low_free) low_free = t;
						coalesce(t);
					end
					rs.status = ST_DONE;
					rs.payload = 12'(rq.offset);
				end
			end
		end
		return rs;
	endfunction

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// handshake capture at the rising edge
	always @(posedge clk) begin
		in_acc <= arst_n && s_axis_tvalid && s_axis_tready;
		out_acc <= arst_n && m_axis_tvalid && m_axis_tready;
	end

	// request driver: changes on falling edge, holds valid until accepted
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			send_gap <= 0;
		end else if (s_axis_tvalid && !in_acc) begin
			// hold
		end else if (send_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_reqs.size() > 0) begin
			request_t rq;
			rq = pending_reqs.pop_front();
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {rq.offset, rq.size};
			s_axis_tuser <= rq.kind;
			expected_rsps.push_back(heap_apply(rq));
			send_gap <= $urandom_range(0, 4);
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// response sink: after each taken item, randomly stall before taking the next
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
		end else if (recv_gap > 0) begin
			m_axis_tready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else if (out_acc) begin
			recv_draw = $urandom_range(0, 4);
			m_axis_tready <= (recv_draw == 0);
			recv_gap <= (recv_draw > 0) ? int'(recv_draw) - 1 : 0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// config channel
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_data <= MIN_SPLIT_RESET;
		end else if (cfg_valid && !cfg_ready) begin
			// hold
		end else if (cfg_req && !cfg_valid) begin
			cfg_valid <= 1'b1;
			cfg_data <= cfg_val;
		end else begin
			cfg_valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			split_min <= cfg_data;
			cfg_req <= 1'b0;
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			response_t ex;
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response status=%0d payload=%0d",
						m_axis_tuser, m_axis_tdata[11:0]);
			end else begin
				ex = expected_rsps.pop_front();
				if (m_axis_tuser !== ex.status || m_axis_tdata !== {4'd0, ex.payload}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected status=%0d payload=%0d, got status=%0d tdata=%h",
							ex.status, ex.payload, m_axis_tuser, m_axis_tdata);
				end
			end
		end
	end

	task automatic push_req(logic [1:0] k, logic [15:0] sz, logic [15:0] off);
		request_t rq;
		rq.kind = k;
		rq.size = sz;
		rq.offset = off;
		pending_reqs.push_back(rq);
	endtask

	// wait for all items to drain, then write min_split_bytes
	task automatic set_split(logic [7:0] v);
		wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !s_axis_tvalid);
		repeat (40) @(posedge clk);
		cfg_val = v;
		cfg_req = 1'b1;
		wait (!cfg_req);
		@(posedge clk);
	endtask

	// random sequence: mostly allocations, frees and shrinks of candidate offsets, some noise
	task automatic random_phase(int count);
		int unsigned sel, off;
		logic [15:0] sz;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0) sz = 16'($urandom);
			else if ($urandom_range(0, 3) == 0) sz = 16'($urandom_range(0, 1024));
			else sz = 16'($urandom_range(0, 96));
			if (live_blocks.size() > 0) off = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
			else off = HDR;
			if (sel < 40) begin
				push_req(KIND_ALLOC, sz, 16'($urandom));
			end else if (sel < 65) begin
				push_req(KIND_FREE, 16'($urandom), 16'(off));
			end else if (sel < 85) begin
				push_req(KIND_SHRINK, sz, 16'(off));
			end else if (sel < 92) begin
				push_req(2'($urandom_range(1, 2)), sz, 16'($urandom));
			end else if (sel < 96) begin
				push_req(2'($urandom_range(1, 2)), sz, 16'($urandom_range(0, 4200)));
			end else begin
				push_req(2'd3, 16'($urandom), 16'($urandom));
			end
			// track random aligned payload offsets as candidates for free and shrink
			if (live_blocks.size() < 64 && sel < 40)
				live_blocks.push_back(HDR + 4 * $urandom_range(0, 300));
			if (live_blocks.size() > 48) void'(live_blocks.pop_front());
		end
	endtask

	// stimulus
	initial begin
		mismatches = 0;
		stim_done = 0;
		cfg_req = 0;
		cfg_val = MIN_SPLIT_RESET;
		heap_clear();
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: special cases and extremes
		push_req(KIND_ALLOC, 16'd0, 16'd0);            // zero size
		push_req(KIND_ALLOC, 16'hFFFF, 16'hFFFF);      // oversize
		push_req(KIND_ALLOC, 16'd4096, 16'd0);         // cannot fit with headers
		push_req(KIND_ALLOC, 16'd1, 16'd0);
		push_req(KIND_ALLOC, 16'd13, 16'd0);
		push_req(KIND_ALLOC, 16'd100, 16'd0);
		push_req(KIND_FREE, 16'd0, 16'd16);            // not a block header
		push_req(KIND_FREE, 16'd0, 16'd16);            // same offset again
		push_req(KIND_FREE, 16'd0, 16'd4);             // below header size
		push_req(KIND_FREE, 16'd0, 16'd17);            // not a header
		push_req(KIND_FREE, 16'hFFFF, 16'hFFFF);       // past end
		push_req(KIND_SHRINK, 16'd4093, 16'd8);        // size at the heap limit, not oversize
		push_req(KIND_SHRINK, 16'd0, 16'd40);          // shrink to zero
		push_req(KIND_SHRINK, 16'd4, 16'd16);          // offset of no block header
		push_req(KIND_SHRINK, 16'd0, 16'd8);
		push_req(KIND_ALLOC, 16'd3000, 16'd0);
		push_req(KIND_ALLOC, 16'd2000, 16'd0);         // no fit
		push_req(2'd3, 16'hFFFF, 16'hFFFF);            // unknown kind
		push_req(KIND_FREE, 16'd0, 16'd8);
		push_req(KIND_FREE, 16'd0, 16'd48);
		push_req(KIND_ALLOC, 16'd4064, 16'd0);         // nearly the whole heap; no fit here
		push_req(KIND_SHRINK, 16'd0, 16'd8);
		push_req(KIND_FREE, 16'd0, 16'd8);

		// random phases across split thresholds, extremes included
		set_split(8'd0);
		random_phase(400);
		set_split(8'd255);
		random_phase(380);
		set_split(8'($urandom_range(1, 254)));
		random_phase(380);
		set_split(8'd12);
		random_phase(370);

		wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !s_axis_tvalid);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog
	initial begin
		#200000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/ffha_dp.sv
hw/rtl/first_fit_heap_allocator.sv
bench/first_fit_heap_allocator_test.sv
